// ----- sv/avrdsm_pkg.sv -----
`default_nettype none

package avrdsm_pkg;

  // byte address width, one bit above the 16-bit space for the word high byte
  localparam int unsigned BYTE_ADDR_W = 17;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned CFG_IDX_W   = 1;

  // action codes
  localparam logic [1:0] ACT_RD_BYTE = 2'd0;
  localparam logic [1:0] ACT_WR_BYTE = 2'd1;
  localparam logic [1:0] ACT_RD_WORD = 2'd2;
  localparam logic [1:0] ACT_WR_WORD = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_START = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_END   = 1'd1;

  localparam logic [15:0] RAM_START_RST = 16'd256;
  localparam logic [15:0] RAM_END_RST   = 16'd2303;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] address;
    logic [15:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        address_wrapped;
    logic        uninitialized_read;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic load_item;
    logic set_wrapped;
    logic set_zero;
    logic mod_start;
    logic mod_sel_depth;
    logic load_mod;
    logic mem_wr;
    logic capture;
    logic next_byte;
    logic load_out;
  } dsm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic above_end;
    logic end_zero;
    logic over_depth;
    logic is_write;
    logic is_word;
    logic byte_hi;
    logic mod_done;
    logic out_free;
  } dsm_status_t;

endpackage

`default_nettype wire

// ----- sv/avrdsm_mod.sv -----
`default_nettype none

module avrdsm_mod import avrdsm_pkg::*; (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  input  wire  [BYTE_ADDR_W-1:0] dividend,
  input  wire  [BYTE_ADDR_W-1:0] divisor,
  output logic                   done,
  output logic [BYTE_ADDR_W-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(BYTE_ADDR_W + 1);
  localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(BYTE_ADDR_W);

  logic                   busy_r, done_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [BYTE_ADDR_W-1:0] rem_r, dvd_r, dvs_r;
  logic [BYTE_ADDR_W:0]   trial;
  logic [BYTE_ADDR_W-1:0] rem_nxt;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {rem_r, dvd_r[BYTE_ADDR_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = BYTE_ADDR_W'(trial - {1'b0, dvs_r});
    end else begin
      rem_nxt = trial[BYTE_ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_STEPS;
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[BYTE_ADDR_W-2:0], 1'b0};
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- sv/avrdsm_ctrl.sv -----
`default_nettype none

module avrdsm_ctrl import avrdsm_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  dsm_status_t status,
  output dsm_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESOLVE,
    ST_MOD_WAIT,
    ST_READ_WAIT,
    ST_OUT_WAIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (status.above_end) begin
          cmd.set_wrapped = 1'b1;
          if (status.end_zero) begin
            cmd.set_zero = 1'b1;
          end else begin
            cmd.mod_start = 1'b1;
            state_nxt     = ST_MOD_WAIT;
          end
        end else if (status.over_depth) begin
          cmd.mod_start     = 1'b1;
          cmd.mod_sel_depth = 1'b1;
          state_nxt         = ST_MOD_WAIT;
        end else if (status.is_write) begin
          cmd.mem_wr = 1'b1;
          if (status.is_word && !status.byte_hi) begin
            cmd.next_byte = 1'b1;
          end else if (status.out_free) begin
            cmd.load_out = 1'b1;
            state_nxt    = ST_IDLE;
          end else begin
            state_nxt = ST_OUT_WAIT;
          end
        end else begin
          state_nxt = ST_READ_WAIT;
        end
      end
      ST_MOD_WAIT: begin
        if (status.mod_done) begin
          cmd.load_mod = 1'b1;
          state_nxt    = ST_RESOLVE;
        end
      end
      ST_READ_WAIT: begin
        cmd.capture = 1'b1;
        if (status.is_word && !status.byte_hi) begin
          cmd.next_byte = 1'b1;
          state_nxt     = ST_RESOLVE;
        end else begin
          // last byte and its flag land at this edge, hand off from ST_OUT_WAIT once the output is free
          state_nxt = ST_OUT_WAIT;
        end
      end
      ST_OUT_WAIT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ----- sv/avrdsm_dpath.sv -----
`default_nettype none

module avrdsm_dpath import avrdsm_pkg::*; #(
  parameter int unsigned MEM_DEPTH    = 65536,
  parameter int unsigned SP_LOW_ADDR  = 93,
  parameter int unsigned SP_HIGH_ADDR = 94
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  in_item_t             in_item,
  output out_item_t            out_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  wire                  cfg_we,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [DATA_W-1:0]    cfg_wdata,
  input  dsm_cmd_t             cmd,
  output dsm_status_t          status
);

  localparam int unsigned AW = $clog2(MEM_DEPTH);
  localparam logic [BYTE_ADDR_W-1:0] DEPTH_C = BYTE_ADDR_W'(MEM_DEPTH);
  localparam logic [BYTE_ADDR_W-1:0] SP_LO_C = BYTE_ADDR_W'(SP_LOW_ADDR);
  localparam logic [BYTE_ADDR_W-1:0] SP_HI_C = BYTE_ADDR_W'(SP_HIGH_ADDR);
  localparam logic [AW-1:0]          CLR_LAST_C = AW'(MEM_DEPTH - 1);

  logic [7:0] data_mem [MEM_DEPTH];
  logic       mark_mem [MEM_DEPTH];

  logic [15:0]            ram_start_r, ram_end_r, sp_r;
  logic [AW-1:0]          clr_cnt_r;
  in_item_t               item_r;
  logic [BYTE_ADDR_W-1:0] addr_r;
  logic                   hi_r, wrapped_r, uninit_r;
  logic [7:0]             rd_lo_r, rd_hi_r;
  logic [7:0]             mem_rd_r;
  logic                   mark_rd_r;
  out_item_t              out_r;
  logic                   out_valid_r;

  logic                   is_sp_lo, is_sp_hi;
  logic [7:0]             wr_byte, rd_byte;
  logic [AW-1:0]          mem_addr;
  logic                   data_we, mark_we;
  logic [BYTE_ADDR_W-1:0] mod_divisor, mod_rem;
  logic                   mod_done;

  assign is_sp_lo = (addr_r == SP_LO_C);
  assign is_sp_hi = (addr_r == SP_HI_C);
  assign wr_byte  = hi_r ? item_r.write_data[15:8] : item_r.write_data[7:0];

  assign mem_addr = cmd.clr_en ? clr_cnt_r : addr_r[AW-1:0];
  assign data_we  = cmd.clr_en || (cmd.mem_wr && !is_sp_lo && !is_sp_hi);
  assign mark_we  = cmd.clr_en || cmd.mem_wr;

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[mem_addr] <= cmd.clr_en ? 8'd0 : wr_byte;
    end
    mem_rd_r <= data_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mem_addr] <= !cmd.clr_en;
    end
    mark_rd_r <= mark_mem[mem_addr];
  end

  always_comb begin
    if (is_sp_lo) begin
      rd_byte = sp_r[7:0];
    end else if (is_sp_hi) begin
      rd_byte = sp_r[15:8];
    end else begin
      rd_byte = mem_rd_r;
    end
  end

  assign mod_divisor = cmd.mod_sel_depth ? DEPTH_C : {1'b0, ram_end_r};

  avrdsm_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.mod_start),
    .dividend  (addr_r),
    .divisor   (mod_divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // control and configuration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_start_r <= RAM_START_RST;
      ram_end_r   <= RAM_END_RST;
      sp_r        <= '0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RAM_START: ram_start_r <= cfg_wdata;
          CFG_RAM_END:   ram_end_r   <= cfg_wdata;
          default:       ;
        endcase
      end
      if (cmd.mem_wr && is_sp_lo) begin
        sp_r[7:0] <= wr_byte;
      end
      if (cmd.mem_wr && is_sp_hi) begin
        sp_r[15:8] <= wr_byte;
      end
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r    <= in_item;
      addr_r    <= {1'b0, in_item.address};
      hi_r      <= 1'b0;
      wrapped_r <= 1'b0;
      uninit_r  <= 1'b0;
      rd_lo_r   <= '0;
      rd_hi_r   <= '0;
    end else begin
      if (cmd.set_wrapped) begin
        wrapped_r <= 1'b1;
      end
      if (cmd.set_zero) begin
        addr_r <= '0;
      end else if (cmd.load_mod) begin
        addr_r <= mod_rem;
      end else if (cmd.next_byte) begin
        addr_r <= {1'b0, item_r.address} + BYTE_ADDR_W'(1);
        hi_r   <= 1'b1;
      end
      if (cmd.capture) begin
        if (hi_r) begin
          rd_hi_r <= rd_byte;
        end else begin
          rd_lo_r <= rd_byte;
        end
        if (addr_r >= {1'b0, ram_start_r} && !mark_rd_r) begin
          uninit_r <= 1'b1;
        end
      end
    end
    if (cmd.load_out) begin
      out_r.read_data          <= {rd_hi_r, rd_lo_r};
      out_r.address_wrapped    <= wrapped_r;
      out_r.uninitialized_read <= uninit_r;
    end
  end

  assign status.clr_last   = (clr_cnt_r == CLR_LAST_C);
  assign status.above_end  = (addr_r > {1'b0, ram_end_r});
  assign status.end_zero   = (ram_end_r == 16'd0);
  assign status.over_depth = (addr_r >= DEPTH_C);
  assign status.is_write   = (item_r.action == ACT_WR_BYTE) || (item_r.action == ACT_WR_WORD);
  assign status.is_word    = (item_r.action == ACT_RD_WORD) || (item_r.action == ACT_WR_WORD);
  assign status.byte_hi    = hi_r;
  assign status.mod_done   = mod_done;
  assign status.out_free   = !out_valid_r || !out_stall;

  assign out_item  = out_r;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- sv/avr_data_space_memory_unit.sv -----
`default_nettype none

// channel   | ports                               | transfer when
// ----------+-------------------------------------+---------------------------
// input     | in_valid, in_stall, in_item         | in_valid && !in_stall
// result    | out_valid, out_stall, out_item      | out_valid && !out_stall
// config    | cfg_we, cfg_index, cfg_wdata        | cfg_we
//
// each byte whose address lies above ram_end (or beyond the store) is reduced
//   in the bit-serial remainder unit, one dividend bit per cycle, or sent to
//   address 0 when ram_end is zero
// reset: a clearing pass over all MEM_DEPTH entries zeroes the byte store and
//   the written marks one entry a cycle; in_stall stays high until it ends
// the result sits in an output register, so the next item is taken while a
//   finished result is still stalled; only a second result waits for it

module avr_data_space_memory_unit import avrdsm_pkg::*; #(
  parameter int unsigned MEM_DEPTH    = 65536,
  parameter int unsigned SP_LOW_ADDR  = 93,
  parameter int unsigned SP_HIGH_ADDR = 94
) (
  input  wire                  clk,
  input  wire                  rst_n,
  // input channel
  input  wire                  in_valid,
  output logic                 in_stall,
  input  in_item_t             in_item,
  // result channel
  output logic                 out_valid,
  input  wire                  out_stall,
  output out_item_t            out_item,
  // configuration writes
  input  wire                  cfg_we,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [DATA_W-1:0]    cfg_wdata
);

  dsm_cmd_t    cmd;
  dsm_status_t status;

  // sequencer: clear pass, address resolve, byte access, result hand-off
  avrdsm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // store, stack pointer, config registers, remainder unit, output register
  avrdsm_dpath #(
    .MEM_DEPTH    (MEM_DEPTH),
    .SP_LOW_ADDR  (SP_LOW_ADDR),
    .SP_HIGH_ADDR (SP_HIGH_ADDR)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
module tb;
  import avrdsm_pkg::*;

  localparam int STORE_DEPTH   = 65536;
  localparam int SP_LOW        = 93;
  localparam int SP_HIGH       = 94;
  // slowest item is a word read with both bytes wrapped
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_wdata = '0;

  avr_data_space_memory_unit #(
    .MEM_DEPTH   (STORE_DEPTH),
    .SP_LOW_ADDR (SP_LOW),
    .SP_HIGH_ADDR(SP_HIGH)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // 10 unit clock, reset held low at the start and then released
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // shadow of the data space: byte store, written marks, stack pointer, config
  // ---------------------------------------------------------------------------
  logic [7:0]  shadow_mem [STORE_DEPTH];
  bit          shadow_marks [STORE_DEPTH];
  logic [15:0] shadow_sp;
  logic [15:0] ram_start_q = RAM_START_RST;
  logic [15:0] ram_end_q   = RAM_END_RST;
  // flags gathered over the one or two bytes of the access in progress
  logic        acc_wrapped;
  logic        acc_uninit;

  out_item_t   expected_results[$];
  bit          quiet_stretch = 1'b0;
  int          errors = 0;
  int          items_sent = 0;
  int          settings_seen = 1;
  int          wraps_seen = 0;
  int          uninit_seen = 0;
  int          stall_left = 0;
  int          cycle_count = 0;

  // reduce a 17-bit byte address past ram_end, then fold into the store
  function automatic logic [15:0] map_addr(input logic [16:0] a);
    int unsigned r;
    r = a;
    if (r > ram_end_q) begin
      acc_wrapped = 1'b1;
      // zero ram_end sends every overflowing byte to address 0
      r = (ram_end_q == 16'd0) ? 0 : r % ram_end_q;
    end
    return 16'(r % STORE_DEPTH);
  endfunction

  function automatic void store_byte(input logic [16:0] a, input logic [7:0] v);
    logic [15:0] r;
    r = map_addr(a);
    shadow_marks[r] = 1'b1;
    // the two stack pointer bytes are redirected but still get their mark
    if (r == SP_LOW) shadow_sp[7:0] = v;
    else if (r == SP_HIGH) shadow_sp[15:8] = v;
    else shadow_mem[r] = v;
  endfunction

  function automatic logic [7:0] fetch_byte(input logic [16:0] a);
    logic [15:0] r;
    r = map_addr(a);
    if (r >= ram_start_q && !shadow_marks[r]) acc_uninit = 1'b1;
    if (r == SP_LOW) return shadow_sp[7:0];
    if (r == SP_HIGH) return shadow_sp[15:8];
    return shadow_mem[r];
  endfunction

  function automatic out_item_t predict_access(input in_item_t it);
    out_item_t   res;
    logic [16:0] lo_addr;
    logic [16:0] hi_addr;
    logic [7:0]  lo;
    logic [7:0]  hi;
    lo_addr = {1'b0, it.address};
    // high byte address kept in 17 bits so 65535 + 1 overflows ram_end
    hi_addr = lo_addr + 17'd1;
    acc_wrapped = 1'b0;
    acc_uninit = 1'b0;
    res.read_data = '0;
    case (it.action)
      ACT_RD_BYTE: begin
        res.read_data = {8'h00, fetch_byte(lo_addr)};
      end
      ACT_WR_BYTE: begin
        store_byte(lo_addr, it.write_data[7:0]);
      end
      ACT_RD_WORD: begin
        lo = fetch_byte(lo_addr);
        hi = fetch_byte(hi_addr);
        res.read_data = {hi, lo};
      end
      default: begin
        store_byte(lo_addr, it.write_data[7:0]);
        store_byte(hi_addr, it.write_data[15:8]);
      end
    endcase
    res.address_wrapped = acc_wrapped;
    res.uninitialized_read = acc_uninit;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one input transfer; valid stays high into the next call when it has no gap
  task automatic send_item(input logic [1:0] act, input logic [15:0] addr,
                           input logic [15:0] wdata);
    in_item_t it;
    int       gap;
    it.action = act;
    it.address = addr;
    it.write_data = wdata;
    gap = quiet_stretch ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_access(it));
    items_sent++;
  endtask

  // drop valid, let every result come back, then give the block time to settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RAM_START) ram_start_q = val;
    else ram_end_q = val;
  endtask

  // addresses lean on the interesting spots of the current map
  function automatic logic [15:0] pick_address();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 31));
      1: return 16'($urandom_range(SP_LOW - 1, SP_HIGH + 1));
      2: return ram_start_q + 16'($urandom_range(0, 4)) - 16'd2;
      3: return ram_end_q + 16'($urandom_range(0, 3)) - 16'd1;
      4: return 16'hFFFF - 16'($urandom_range(0, 1));
      5: return 16'($urandom);
      // small hot window so reads often find written bytes
      default: return ram_start_q + 16'($urandom_range(0, 47));
    endcase
  endfunction

  task automatic random_access();
    logic [15:0] a;
    logic [1:0]  wr_code;
    logic [1:0]  rd_code;
    bit          is_word;
    if ($urandom_range(0, 49) == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
    a = pick_address();
    is_word = ($urandom_range(0, 1) == 1);
    wr_code = is_word ? ACT_WR_WORD : ACT_WR_BYTE;
    rd_code = is_word ? ACT_RD_WORD : ACT_RD_BYTE;
    if ($urandom_range(0, 3) == 0) begin
      // write then read back the same spot
      send_item(wr_code, a, 16'($urandom));
      send_item(rd_code, a, 16'($urandom));
    end else begin
      send_item($urandom_range(0, 1) ? wr_code : rd_code, a, 16'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // stack pointer bytes via byte and word accesses
  task automatic test_stack_pointer_bytes();
    send_item(ACT_WR_BYTE, 16'(SP_LOW), 16'h00A5);
    send_item(ACT_WR_BYTE, 16'(SP_HIGH), 16'h005A);
    send_item(ACT_RD_WORD, 16'(SP_LOW), 16'h0000);
    send_item(ACT_WR_WORD, 16'(SP_LOW), 16'hFFFF);
    send_item(ACT_RD_BYTE, 16'(SP_HIGH), 16'h0000);
    send_item(ACT_RD_BYTE, 16'(SP_LOW), 16'h0000);
  endtask

  // field extremes, sram boundary, last valid byte and the top of the space
  task automatic test_field_extremes();
    send_item(ACT_WR_WORD, 16'h0000, 16'h0000);
    send_item(ACT_RD_BYTE, 16'h0000, 16'hFFFF);
    send_item(ACT_RD_WORD, RAM_START_RST, 16'h0000);
    send_item(ACT_WR_WORD, RAM_START_RST, 16'hFFFF);
    send_item(ACT_RD_WORD, RAM_START_RST, 16'h0000);
    send_item(ACT_WR_BYTE, RAM_END_RST, 16'hFF80);
    send_item(ACT_RD_WORD, RAM_END_RST, 16'h0000);
    send_item(ACT_RD_BYTE, 16'hFFFF, 16'h0000);
    send_item(ACT_WR_WORD, 16'hFFFF, 16'h1234);
    send_item(ACT_RD_WORD, 16'hFFFF, 16'h0000);
  endtask

  // ram_end of zero folds everything above address 0 onto it
  task automatic test_zero_ram_end();
    set_config(CFG_RAM_END, 16'd0);
    settings_seen++;
    send_item(ACT_RD_BYTE, 16'd5, 16'h0000);
    send_item(ACT_WR_WORD, 16'd100, 16'hBEEF);
    send_item(ACT_RD_BYTE, 16'd0, 16'h0000);
    send_item(ACT_RD_WORD, 16'hFFFF, 16'h0000);
  endtask

  task automatic test_random_traffic(input logic [15:0] start_val,
                                     input logic [15:0] end_val, input int n);
    int first;
    set_config(CFG_RAM_START, start_val);
    set_config(CFG_RAM_END, end_val);
    settings_seen++;
    first = items_sent;
    while (items_sent - first < n) random_access();
  endtask

  // sender holds off until the block has drained, then bursts again
  task automatic test_drain_then_burst();
    repeat (20) random_access();
    wait_idle();
    repeat (20) random_access();
  endtask

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) shadow_mem[i] = 8'h00;
    shadow_sp = '0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    test_stack_pointer_bytes();
    test_field_extremes();
    test_zero_ram_end();
    test_random_traffic(16'd0, 16'hFFFF, 350);
    test_random_traffic(16'hFFFF, 16'd32, 200);
    test_random_traffic(16'd32, 16'd0, 100);
    test_random_traffic(RAM_START_RST, RAM_END_RST, 350);
    test_random_traffic(16'($urandom_range(32, 65535)), 16'($urandom_range(32, 65535)), 200);
    test_random_traffic(16'($urandom_range(32, 65535)), 16'($urandom_range(32, 65535)), 200);
    test_drain_then_burst();
    wait_idle();
    $display("ran %0d byte and word accesses under %0d ram_start/ram_end settings",
             items_sent, settings_seen);
    $display("%0d results came back wrapped, %0d flagged an uninitialized read",
             wraps_seen, uninit_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: random stall before each transfer, field by field check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (wraps_seen >= 0 && out_item.address_wrapped) wraps_seen++;
      if (out_item.uninitialized_read) uninit_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_item.read_data !== want.read_data) begin
          $display("%0t: read_data expected %h actual %h",
                   $time, want.read_data, out_item.read_data);
          errors++;
        end
        if (out_item.address_wrapped !== want.address_wrapped) begin
          $display("%0t: address_wrapped expected %b actual %b",
                   $time, want.address_wrapped, out_item.address_wrapped);
          errors++;
        end
        if (out_item.uninitialized_read !== want.uninitialized_read) begin
          $display("%0t: uninitialized_read expected %b actual %b",
                   $time, want.uninitialized_read, out_item.uninitialized_read);
          errors++;
        end
      end
      // stall count drawn for the next result
      stall_left = quiet_stretch ? 0 : $urandom_range(0, 7);
    end else if (out_valid && stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  // watchdog, covers the clearing pass after reset as well
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule

// ----- avr_data_space_memory_unit.f -----
sv/avrdsm_pkg.sv
sv/avrdsm_mod.sv
sv/avrdsm_ctrl.sv
sv/avrdsm_dpath.sv
sv/avr_data_space_memory_unit.sv
sim/tb.sv
